[rtl/rbd_pkg.sv]
// Shared constants, types and helpers of the RGB 4x4 box downsampler.
package rbd_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;

    localparam int DIM_W      = 12;
    localparam int SAMPLE_W   = 8;
    localparam int SUM_W      = 12;
    localparam int BLOCK_SHIFT = 2;

    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int BLOCK_COLS = MAX_WIDTH / 4;
    localparam int IDX_W      = $clog2(BLOCK_COLS);

    localparam int CNT_MAX_W  = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int CALC_W     = ((CNT_MAX_W > DIM_W) ? CNT_MAX_W : DIM_W) + 1;

    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 3;
    localparam int REG_IDX_W  = 1;

    localparam logic [SUM_W-1:0]  ROUND_BIAS     = SUM_W'(8);
    localparam logic [DIM_W-1:0]  WIDTH_RESET    = DIM_W'(640);
    localparam logic [DIM_W-1:0]  HEIGHT_RESET   = DIM_W'(480);

    typedef enum logic [REG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] red;
        logic [SAMPLE_W-1:0] green;
        logic [SAMPLE_W-1:0] blue;
    } pixel_t;

    // Red in the low bits, then green, then blue.
    typedef struct packed {
        logic [SUM_W-1:0] blue;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] red;
    } sums_t;

    typedef struct packed {
        logic             in_range;
        logic             fresh;
        logic             last;
        logic             done;
        logic [IDX_W-1:0] idx;
    } pos_t;

    // Clamp a programmed dimension: zero acts as one, oversize acts as the maximum.
    function automatic logic [CALC_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                                  input logic [CALC_W-1:0] maxv);
        logic [CALC_W-1:0] ext;
        ext = CALC_W'(v);
        if (ext == '0)
        begin
            return CALC_W'(1);
        end
        else if (ext > maxv)
        begin
            return maxv;
        end
        return ext;
    endfunction

    function automatic logic [SUM_W-1:0] add_sample(input logic [SUM_W-1:0] base,
                                                    input logic [SAMPLE_W-1:0] samp);
        return base + SUM_W'(samp);
    endfunction

endpackage

[rtl/rbd_ifs.sv]
// Valid/ready channel interfaces for input pixels and thumbnail pixels.
interface rbd_pixel_if import rbd_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] red_in;
    logic [SAMPLE_W-1:0] green_in;
    logic [SAMPLE_W-1:0] blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    output ready);
endinterface

interface rbd_thumb_if import rbd_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] thumb_red;
    logic [SAMPLE_W-1:0] thumb_green;
    logic [SAMPLE_W-1:0] thumb_blue;
    logic                frame_done;

    modport source (output valid, output thumb_red, output thumb_green,
                    output thumb_blue, output frame_done, input ready);
    modport sink   (input valid, input thumb_red, input thumb_green,
                    input thumb_blue, input frame_done, output ready);
endinterface

[rtl/rgb_box_downsample_4x4.sv]
// Top level of the RGB 4x4 box-filter downsampler.
// Takes one RGB pixel per clock in raster order, the rate set by the single
// read and single write port of the line buffer, unless the thumbnail output stalls,
// and emits one thumbnail pixel, the rounded per-channel average of each 4x4 block,
// when the block's bottom-right pixel has been taken; frame_done marks the frame's
// last thumbnail pixel. Columns and rows past the last multiple of 4 are dropped. A
// pixel is taken into an input register while its line-buffer entry is read; when
// that register advances, its sums are written back and the result is loaded into
// the output register. Program frame_width and frame_height only while idle.
module rgb_box_downsample_4x4 import rbd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    rbd_pixel_if.sink             pixel,
    rbd_thumb_if.source           thumb
);

    logic [DIM_W-1:0] frame_width;
    logic [DIM_W-1:0] frame_height;
    pos_t             pos;
    logic             in_fire;

    logic             s_valid_reg;
    logic             s_valid_next;
    pos_t             s_pos_reg;
    pixel_t           s_pix_reg;
    logic             s_emit;
    logic             s_adv;

    sums_t            lb_rd_data;
    sums_t            base;
    sums_t            sum_new;

    logic             out_valid_reg;
    logic             out_valid_next;
    pixel_t           out_pix_reg;
    logic             out_done_reg;

    rbd_apb_regs u_regs
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .frame_width  (frame_width),
        .frame_height (frame_height)
    );

    rbd_position u_pos
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (in_fire),
        .frame_width  (frame_width),
        .frame_height (frame_height),
        .pos          (pos)
    );

    rbd_line_buf u_lbuf
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_fire),
        .rd_idx  (pos.idx),
        .wr_en   (s_adv & s_pos_reg.in_range),
        .wr_idx  (s_pos_reg.idx),
        .wr_data (sum_new),
        .rd_data (lb_rd_data)
    );

    assign in_fire     = pixel.valid & pixel.ready;
    assign s_emit      = s_pos_reg.in_range & s_pos_reg.last;
    // Advance unless a result would overwrite one still waiting.
    assign s_adv       = s_valid_reg & (~s_emit | ~out_valid_reg | thumb.ready);
    assign pixel.ready = ~s_valid_reg | s_adv;

    always_comb
    begin
        if (s_pos_reg.fresh)
        begin
            base = '{blue: ROUND_BIAS, green: ROUND_BIAS, red: ROUND_BIAS};
        end
        else
        begin
            base = lb_rd_data;
        end
        sum_new.red   = add_sample(base.red,   s_pix_reg.red);
        sum_new.green = add_sample(base.green, s_pix_reg.green);
        sum_new.blue  = add_sample(base.blue,  s_pix_reg.blue);
    end

    assign s_valid_next   = in_fire | (s_valid_reg & ~s_adv);
    assign out_valid_next = (s_adv & s_emit) | (out_valid_reg & ~thumb.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s_valid_reg   <= s_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s_pos_reg       <= pos;
            s_pix_reg.red   <= pixel.red_in;
            s_pix_reg.green <= pixel.green_in;
            s_pix_reg.blue  <= pixel.blue_in;
        end
        if (s_adv && s_emit)
        begin
            out_pix_reg.red   <= sum_new.red[SUM_W-1:SUM_W-SAMPLE_W];
            out_pix_reg.green <= sum_new.green[SUM_W-1:SUM_W-SAMPLE_W];
            out_pix_reg.blue  <= sum_new.blue[SUM_W-1:SUM_W-SAMPLE_W];
            out_done_reg      <= s_pos_reg.done;
        end
    end

    assign thumb.valid       = out_valid_reg;
    assign thumb.thumb_red   = out_pix_reg.red;
    assign thumb.thumb_green = out_pix_reg.green;
    assign thumb.thumb_blue  = out_pix_reg.blue;
    assign thumb.frame_done  = out_done_reg;

    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (s_adv && s_emit) |-> (!out_valid_reg || thumb.ready))
        else $error("result loaded over a pending thumbnail pixel");

    a_request_lands: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> s_valid_reg)
        else $error("accepted pixel missing from input register");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s_valid_reg && !s_adv) |=> (s_valid_reg && $stable(s_pos_reg)
                                     && $stable(s_pix_reg)))
        else $error("stalled pixel changed in input register");

endmodule

[rtl/rbd_apb_regs.sv]
// APB configuration registers: frame width and frame height.
module rbd_apb_regs import rbd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [DIM_W-1:0]      frame_width,
    output logic [DIM_W-1:0]      frame_height
);

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] width_next;
    logic [DIM_W-1:0] height_reg;
    logic [DIM_W-1:0] height_next;
    logic             wr_en;
    reg_idx_t         reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_FRAME_WIDTH:  width_next  = pwdata[DIM_W-1:0];
                REG_FRAME_HEIGHT: height_next = pwdata[DIM_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_FRAME_WIDTH:  prdata = APB_DATA_W'(width_reg);
            REG_FRAME_HEIGHT: prdata = APB_DATA_W'(height_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    assign frame_width  = width_reg;
    assign frame_height = height_reg;

endmodule

[rtl/rbd_position.sv]
// Raster position counters and per-pixel block flags.
module rbd_position import rbd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic [DIM_W-1:0] frame_width,
    input  logic [DIM_W-1:0] frame_height,
    output pos_t             pos
);

    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;
    logic [CALC_W-1:0] w;
    logic [CALC_W-1:0] h;
    logic [CALC_W-1:0] w_blk;
    logic [CALC_W-1:0] h_blk;
    logic [CALC_W-1:0] col_ext;
    logic [CALC_W-1:0] row_ext;
    logic [CALC_W-1:0] col_inc;
    logic [CALC_W-1:0] row_inc;

    assign w       = eff_dim(frame_width,  CALC_W'(MAX_WIDTH));
    assign h       = eff_dim(frame_height, CALC_W'(MAX_HEIGHT));
    assign w_blk   = w >> BLOCK_SHIFT;
    assign h_blk   = h >> BLOCK_SHIFT;
    assign col_ext = CALC_W'(col_reg);
    assign row_ext = CALC_W'(row_reg);
    assign col_inc = col_ext + CALC_W'(1);
    assign row_inc = row_ext + CALC_W'(1);

    always_comb
    begin
        pos.in_range = (col_ext < (w_blk << BLOCK_SHIFT)) && (row_ext < (h_blk << BLOCK_SHIFT));
        pos.fresh    = (col_reg[1:0] == 2'b00) && (row_reg[1:0] == 2'b00);
        pos.last     = (col_reg[1:0] == 2'b11) && (row_reg[1:0] == 2'b11);
        pos.done     = ((col_ext >> BLOCK_SHIFT) == (w_blk - CALC_W'(1)))
                    && ((row_ext >> BLOCK_SHIFT) == (h_blk - CALC_W'(1)));
        pos.idx      = col_reg[IDX_W+BLOCK_SHIFT-1:BLOCK_SHIFT];
    end

    // Wrap the column at the row end, the row at the frame end.
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (advance)
        begin
            if (col_inc >= w)
            begin
                col_next = '0;
                row_next = (row_inc >= h) ? '0 : ROW_W'(row_inc);
            end
            else
            begin
                col_next = COL_W'(col_inc);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

[rtl/rbd_line_buf.sv]
// Line buffer of partial block sums with registered read and write forwarding.
module rbd_line_buf import rbd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_idx,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_idx,
    input  sums_t            wr_data,
    output sums_t            rd_data
);

    sums_t mem [BLOCK_COLS];
    sums_t rdata_reg;
    sums_t fwd_data_reg;
    logic  fwd_reg;
    logic  fwd_next;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg    <= mem[rd_idx];
            fwd_data_reg <= wr_data;
        end
    end

    // Take the write data instead when a read hits the entry written in the same cycle.
    assign fwd_next = rd_en ? (wr_en && (wr_idx == rd_idx)) : fwd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else
        begin
            fwd_reg <= fwd_next;
        end
    end

    assign rd_data = fwd_reg ? fwd_data_reg : rdata_reg;

endmodule
